// ----- sv/tcmv_pkg.sv -----
// Shared constants, K-type breakpoint tables and types for the thermocouple converter.
`timescale 1ns / 1ps

package tcmv_pkg;

  localparam int POS_SEGMENTS        = 40;
  localparam int NEG_SEGMENTS        = 20;
  localparam int DEGREES_PER_SEGMENT = 10;

  localparam int POS_TABLE_SIZE = 40;
  localparam int NEG_TABLE_SIZE = 20;
  localparam int TAB_N = (POS_TABLE_SIZE > NEG_TABLE_SIZE) ? POS_TABLE_SIZE : NEG_TABLE_SIZE;

  // breakpoint counts, clamped to the built-in tables
  localparam int POS_N = (POS_SEGMENTS > POS_TABLE_SIZE) ? POS_TABLE_SIZE :
                         ((POS_SEGMENTS < 1) ? 1 : POS_SEGMENTS);
  localparam int NEG_N = (NEG_SEGMENTS > NEG_TABLE_SIZE) ? NEG_TABLE_SIZE :
                         ((NEG_SEGMENTS < 1) ? 1 : NEG_SEGMENTS);

  localparam int STEP = DEGREES_PER_SEGMENT * 100;

  localparam int MV_W   = 16;
  localparam int MAG_W  = 16;
  localparam int BP_W   = 14;
  localparam int SPAN_W = 9;
  localparam int SEG_W  = $clog2(TAB_N);
  localparam int POS_IW = $clog2(POS_TABLE_SIZE);
  localparam int NEG_IW = $clog2(NEG_TABLE_SIZE);
  localparam int QW     = $clog2(STEP + 1);
  localparam int NUM_W  = SPAN_W + QW;
  localparam int TEMP_W = 17;

  typedef logic [BP_W-1:0]   bp_t;
  typedef logic [SEG_W-1:0]  seg_t;
  typedef logic [TEMP_W-1:0] temp_t;

  // breakpoint magnitudes in microvolts, one every DEGREES_PER_SEGMENT degrees
  localparam bp_t POS_UV [POS_TABLE_SIZE] = '{
    14'd0,     14'd397,   14'd798,   14'd1203,  14'd1612,
    14'd2023,  14'd2436,  14'd2851,  14'd3267,  14'd3682,
    14'd4096,  14'd4509,  14'd4920,  14'd5328,  14'd5735,
    14'd6138,  14'd6540,  14'd6941,  14'd7340,  14'd7739,
    14'd8138,  14'd8539,  14'd8940,  14'd9343,  14'd9747,
    14'd10153, 14'd10561, 14'd10971, 14'd11382, 14'd11795,
    14'd12209, 14'd12624, 14'd13040, 14'd13457, 14'd13874,
    14'd14293, 14'd14713, 14'd15133, 14'd15554, 14'd15975
  };

  localparam bp_t NEG_MAG [NEG_TABLE_SIZE] = '{
    14'd0,    14'd392,  14'd778,  14'd1156, 14'd1527,
    14'd1889, 14'd2243, 14'd2587, 14'd2920, 14'd3243,
    14'd3554, 14'd3852, 14'd4138, 14'd4411, 14'd4669,
    14'd4913, 14'd5141, 14'd5354, 14'd5550, 14'd5730
  };

  localparam bp_t POS_TOP = POS_UV[POS_N-1];
  localparam bp_t NEG_TOP = NEG_MAG[NEG_N-1];

  function automatic bp_t pos_bp(int k);
    if (k >= 0 && k < POS_TABLE_SIZE) return POS_UV[POS_IW'(k)];
    return '1;
  endfunction

  function automatic bp_t neg_bp(int k);
    if (k >= 0 && k < NEG_TABLE_SIZE) return NEG_MAG[NEG_IW'(k)];
    return '1;
  endfunction

  function automatic bp_t side_bp(logic neg, seg_t idx);
    if (neg) begin
      if (int'(idx) < NEG_TABLE_SIZE) return NEG_MAG[idx[NEG_IW-1:0]];
      return '1;
    end
    if (int'(idx) < POS_TABLE_SIZE) return POS_UV[idx[POS_IW-1:0]];
    return '1;
  endfunction

  // item fields that ride alongside the divider
  typedef struct packed {
    logic  neg;
    logic  err;
    temp_t base;
  } tcmv_side_t;

endpackage

// ----- sv/thermocouple_mv_to_temperature.sv -----
// Top level: K-type thermocouple microvolts to interpolated centidegrees.
`timescale 1ns / 1ps

// Takes one signed microvolt sample per cycle while in_stall is low and returns
// the K-type temperature in hundredths of a degree, linearly interpolated within
// 10-degree segments and rounded toward zero; samples beyond the table span give 0
// with out_range_error set. Pipeline: compare, segment encode, table lookup, scale,
// one restoring-divider stage per quotient bit, and the output register. Throughput
// is one item per cycle while unstalled; out_stall holds only the stages that hold
// an item, so empty stages keep filling while a result waits.
module thermocouple_mv_to_temperature
  import tcmv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [MV_W-1:0]   in_mv_microvolts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temp_centidegrees,
  output logic                     out_range_error
);

  // stage 1: magnitude and breakpoint compares
  logic               neg_nxt;
  logic [MAG_W-1:0]   mag_nxt;
  logic [TAB_N-1:1]   gt_nxt;
  logic               err_nxt;
  logic               v1_r, neg1_r, err1_r;
  logic [MAG_W-1:0]   mag1_r;
  logic [TAB_N-1:1]   gt1_r;

  // stage 2: segment index
  seg_t               seg_nxt;
  logic               v2_r, neg2_r, err2_r;
  logic [MAG_W-1:0]   mag2_r;
  seg_t               seg2_r;

  // stage 3: distance and span
  bp_t                base_bp;
  bp_t                top_bp;
  logic               v3_r, neg3_r, err3_r;
  logic [SPAN_W-1:0]  dist3_r, span3_r;
  temp_t              base3_r;

  // stage 4: scaled numerator
  logic               v4_r;
  logic [NUM_W-1:0]   num4_r;
  logic [SPAN_W-1:0]  span4_r;
  tcmv_side_t         side4_r;

  // divider and output
  logic               div_in_stall, div_valid;
  logic [QW-1:0]      div_q;
  tcmv_side_t         div_side;
  temp_t              tmag;
  logic               out_v_r, out_err_r;
  temp_t              out_temp_r;

  logic en1, en2, en3, en4, en_out;

  assign en_out = !out_v_r || !out_stall;
  assign en4    = !v4_r || !div_in_stall;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  always_comb begin
    neg_nxt = in_mv_microvolts[MV_W-1];
    mag_nxt = neg_nxt ? MAG_W'(-in_mv_microvolts) : MAG_W'(in_mv_microvolts);
    err_nxt = neg_nxt ? (mag_nxt > MAG_W'(NEG_TOP)) : (mag_nxt > MAG_W'(POS_TOP));
    for (int k = 1; k < TAB_N; k++) begin
      if (neg_nxt) begin
        gt_nxt[k] = (k <= NEG_N - 2) && (mag_nxt > MAG_W'(neg_bp(k)));
      end else begin
        gt_nxt[k] = (k <= POS_N - 2) && (mag_nxt > MAG_W'(pos_bp(k)));
      end
    end
  end

  // compares form a thermometer code; highest set bit is the segment
  always_comb begin
    seg_nxt = '0;
    for (int k = 1; k < TAB_N; k++) begin
      if (gt1_r[k]) seg_nxt = SEG_W'(k);
    end
  end

  assign base_bp = side_bp(neg2_r, seg2_r);
  assign top_bp  = side_bp(neg2_r, seg2_r + SEG_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      neg1_r <= neg_nxt;
      err1_r <= err_nxt;
      mag1_r <= mag_nxt;
      gt1_r  <= gt_nxt;
    end
    if (en2) begin
      neg2_r <= neg1_r;
      err2_r <= err1_r;
      mag2_r <= mag1_r;
      seg2_r <= seg_nxt;
    end
    if (en3) begin
      neg3_r  <= neg2_r;
      err3_r  <= err2_r;
      dist3_r <= SPAN_W'(mag2_r - MAG_W'(base_bp));
      span3_r <= SPAN_W'(top_bp - base_bp);
      base3_r <= TEMP_W'(int'(seg2_r) * STEP);
    end
    if (en4) begin
      num4_r       <= NUM_W'(int'(dist3_r) * STEP);
      span4_r      <= span3_r;
      side4_r.neg  <= neg3_r;
      side4_r.err  <= err3_r;
      side4_r.base <= base3_r;
    end
  end

  tcmv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_stall  (div_in_stall),
    .in_num    (num4_r),
    .in_span   (span4_r),
    .in_side   (side4_r),
    .out_valid (div_valid),
    .out_stall (!en_out),
    .out_q     (div_q),
    .out_side  (div_side)
  );

  assign tmag = TEMP_W'(div_q) + div_side.base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_err_r <= div_side.err;
      if (div_side.err) begin
        out_temp_r <= '0;
      end else begin
        out_temp_r <= div_side.neg ? -tmag : tmag;
      end
    end
  end

  assign in_stall              = !en1;
  assign out_valid             = out_v_r;
  assign out_temp_centidegrees = $signed(out_temp_r);
  assign out_range_error       = out_err_r;

endmodule

// ----- sv/tcmv_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, stall-aware valid chain.
`timescale 1ns / 1ps

module tcmv_div
  import tcmv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUM_W-1:0]    in_num,
  input  logic [SPAN_W-1:0]   in_span,
  input  tcmv_side_t          in_side,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [QW-1:0]       out_q,
  output tcmv_side_t          out_side
);

  logic                v_r    [QW];
  logic [NUM_W-1:0]    rem_r  [QW];
  logic [QW-1:0]       q_r    [QW];
  logic [SPAN_W-1:0]   span_r [QW];
  tcmv_side_t          side_r [QW];
  logic                en     [QW+1];

  assign en[QW] = !out_stall;

  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;
      logic               v_in;
      logic [NUM_W-1:0]   rem_in;
      logic [QW-1:0]      q_in;
      logic [SPAN_W-1:0]  span_in;
      tcmv_side_t         side_in;
      logic [NUM_W-1:0]   dshift;
      logic               take;

      if (i == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = in_num;
        assign q_in    = '0;
        assign span_in = in_span;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = v_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign q_in    = q_r[i-1];
        assign span_in = span_r[i-1];
        assign side_in = side_r[i-1];
      end

      assign en[i]  = !v_r[i] || en[i+1];
      assign dshift = NUM_W'(span_in) << B;
      assign take   = (rem_in >= dshift);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en[i]) begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en[i]) begin
          rem_r[i]  <= take ? (rem_in - dshift) : rem_in;
          q_r[i]    <= q_in | (QW'(take) << B);
          span_r[i] <= span_in;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign in_stall  = !en[0];
  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- dv/tb_thermocouple_mv_to_temperature.sv -----
// Self-checking testbench for the K-type thermocouple microvolt to centidegree converter.
`timescale 1ns / 1ps

module tb_thermocouple_mv_to_temperature
  import tcmv_pkg::*;
();

  // K-type breakpoints in microvolts, one per segment
  localparam int POS_BREAK_UV [40] = '{
    0, 397, 798, 1203, 1612, 2023, 2436, 2851, 3267, 3682,
    4096, 4509, 4920, 5328, 5735, 6138, 6540, 6941, 7340, 7739,
    8138, 8539, 8940, 9343, 9747, 10153, 10561, 10971, 11382, 11795,
    12209, 12624, 13040, 13457, 13874, 14293, 14713, 15133, 15554, 15975
  };
  localparam int NEG_BREAK_UV [20] = '{
    0, -392, -778, -1156, -1527, -1889, -2243, -2587, -2920, -3243,
    -3554, -3852, -4138, -4411, -4669, -4913, -5141, -5354, -5550, -5730
  };

  typedef struct packed {
    logic [TEMP_W-1:0] centideg;
    logic              range_error;
  } conversion_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [MV_W-1:0]   in_mv_microvolts = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_temp_centidegrees;
  logic                     out_range_error;

  conversion_t pending_temps[$];
  conversion_t oldest_temp;
  int          mismatches = 0;
  int          stall_pct = 0;
  int          stall_run = 0;

  thermocouple_mv_to_temperature dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mv_microvolts      (in_mv_microvolts),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temp_centidegrees (out_temp_centidegrees),
    .out_range_error       (out_range_error)
  );

  always #1 clk = ~clk;

  function automatic int clamp_points(int n, int limit);
    if (n < 1) return 1;
    if (n > limit) return limit;
    return n;
  endfunction

  // interpolated temperature, truncated toward zero, wrapped to 17 bits
  function automatic conversion_t interpolate_temp(logic signed [MV_W-1:0] mv);
    conversion_t r;
    int          v;
    int          n;
    int          s;
    longint      step;
    longint      mag;
    r = '0;
    v = mv;
    s = 0;
    step = longint'(DEGREES_PER_SEGMENT) * 100;
    if (v > 0) begin
      n = clamp_points(POS_SEGMENTS, 40);
      if (n < 2 || v > POS_BREAK_UV[n-1]) begin
        r.range_error = 1'b1;
      end else begin
        while (s < n - 2 && v > POS_BREAK_UV[s+1]) s++;
        mag = longint'(v - POS_BREAK_UV[s]) * step / (POS_BREAK_UV[s+1] - POS_BREAK_UV[s])
              + longint'(s) * step;
        r.centideg = mag[TEMP_W-1:0];
      end
    end else if (v < 0) begin
      n = clamp_points(NEG_SEGMENTS, 20);
      if (n < 2 || v < NEG_BREAK_UV[n-1]) begin
        r.range_error = 1'b1;
      end else begin
        while (s < n - 2 && v < NEG_BREAK_UV[s+1]) s++;
        mag = longint'(NEG_BREAK_UV[s] - v) * step / (NEG_BREAK_UV[s] - NEG_BREAK_UV[s+1])
              + longint'(s) * step;
        mag = -mag;
        r.centideg = mag[TEMP_W-1:0];
      end
    end
    return r;
  endfunction

  // mostly in-span voltages, many near breakpoints, some out of span or raw
  function automatic logic signed [MV_W-1:0] pick_voltage();
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 35) return MV_W'($urandom_range(1, 15975));
    if (kind < 60) return MV_W'(-int'($urandom_range(1, 5730)));
    if (kind < 75) begin
      k = $urandom_range(0, 39);
      return MV_W'(POS_BREAK_UV[k] + int'($urandom_range(0, 4)) - 2);
    end
    if (kind < 88) begin
      k = $urandom_range(0, 19);
      return MV_W'(NEG_BREAK_UV[k] + int'($urandom_range(0, 4)) - 2);
    end
    return MV_W'($urandom());
  endfunction

  // receiver back-pressure: runs of stall or no stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
      stall_run <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_temps.size() == 0) begin
        $error("unexpected item: temp_centidegrees=%0d range_error=%0b",
               out_temp_centidegrees, out_range_error);
        mismatches++;
      end else begin
        oldest_temp = pending_temps.pop_front();
        if (out_temp_centidegrees !== oldest_temp.centideg) begin
          $error("temp_centidegrees: expected %0d, got %0d",
                 $signed(oldest_temp.centideg), out_temp_centidegrees);
          mismatches++;
        end
        if (out_range_error !== oldest_temp.range_error) begin
          $error("range_error: expected %0b, got %0b",
                 oldest_temp.range_error, out_range_error);
          mismatches++;
        end
      end
    end
  end

  // holds valid high after acceptance; pause_input lowers it
  task automatic send_sample(input logic signed [MV_W-1:0] mv);
    in_valid <= 1'b1;
    in_mv_microvolts <= mv;
    do @(posedge clk); while (in_stall);
    pending_temps.push_back(interpolate_temp(mv));
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    pause_input(1);
    while (pending_temps.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_values();
    logic signed [MV_W-1:0] vals [$];
    stall_pct = 0;
    vals = '{0, 1, -1, 396, 397, 398, 15554, 15974, 15975, 15976,
             -392, -2919, -2920, -2921, -5729, -5730, -5731,
             16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 4096, -4096, 200, -200};
    foreach (vals[i]) begin
      send_sample(vals[i]);
      pause_input($urandom_range(0, 2));
    end
    drain_results();
  endtask

  task automatic test_full_rate();
    stall_pct = 0;
    repeat (300) send_sample(pick_voltage());
    drain_results();
  endtask

  task automatic test_bursty_traffic();
    int sent;
    int burst;
    sent = 0;
    stall_pct = 25;
    while (sent < 350) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_sample(pick_voltage());
      sent += burst;
      pause_input($urandom_range(0, 8));
    end
    drain_results();
  endtask

  task automatic test_back_pressure();
    int sent;
    int burst;
    sent = 0;
    stall_pct = 75;
    while (sent < 350) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_sample(pick_voltage());
      sent += burst;
      pause_input($urandom_range(0, 3));
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_full_rate();
    test_bursty_traffic();
    test_back_pressure();
    stall_pct = 0;
    repeat (QW + 20) @(posedge clk);
    if (mismatches == 0 && pending_temps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- thermocouple_mv_to_temperature.f -----
sv/tcmv_pkg.sv
sv/tcmv_div.sv
sv/thermocouple_mv_to_temperature.sv
dv/tb_thermocouple_mv_to_temperature.sv
